/* design/wlcs_pkg.sv */
// Package with shared constants, types and a helper function for the peer selector.
package wlcs_pkg;

  localparam int NumPeers = 8;
  localparam int PeerW = 3;

  localparam logic [1:0] StatusChosen  = 2'd0;
  localparam logic [1:0] StatusBusy    = 2'd1;
  localparam logic [1:0] StatusRelease = 2'd2;

  localparam logic [2:0] RegWeights  = 3'd0;
  localparam logic [2:0] RegLimits   = 3'd1;
  localparam logic [2:0] RegWindows  = 3'd2;
  localparam logic [2:0] RegDown     = 3'd3;
  localparam logic [2:0] RegCount    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input transaction
    logic scan_clear; // reset the scan index and scan flags
    logic scan1;      // first scan: find the minimum ratio
    logic scan2;      // second scan: smooth round robin over ties
    logic update;     // apply the select update and build the result
    logic release_op; // apply the release update and build the result
    logic busy_op;    // clear fail counts and build the busy result
  } wlcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_release;
    logic scan_last;
    logic found;
    logic many;
  } wlcs_stat_t;

  function automatic logic [3:0] weight_of(input logic [31:0] w, input logic [PeerW-1:0] i);
    logic [3:0] v;
    v = w[4*i +: 4];
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

endpackage

/* design/weighted_least_conn_select.sv */
// Top level of the weighted least-connections peer selector.
// Usage: a transaction on the input channel (valid/stall) is either a select
// (func 0) or a release (func 1). Each input transaction yields exactly one
// output transaction carrying status, chosen_peer and new_tried_mask.
// A select scans the peers in use one per cycle to find the lowest ratio of
// connections to weight; if several tie, a second scan from the first minimum
// applies smooth weighted round robin. A release is applied in the dispatch
// state; a select with no peer available ends after the first scan, one
// without a tie goes from the first scan to the update, and one with a tie
// runs the second scan before the update. Both scans step sequentially
// through the single comparison unit.
// One transaction is in work at a time; the next is accepted once the result
// is registered and the output slot is free or being taken.
// Reset clears all connection counts, fail counts, check times and smooth
// weights and loads the register defaults. When the receiver stalls, the
// result holds steady and the input stays stalled until the result leaves.
// Configuration is written through cfg_en/cfg_index/cfg_data while idle.
module weighted_least_conn_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] now_seconds,
  input  logic [7:0]  tried_mask,
  input  logic [2:0]  peer_index,
  input  logic        failed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  chosen_peer,
  output logic [7:0]  new_tried_mask
);

  wlcs_pkg::wlcs_cmd_t  cmd;
  wlcs_pkg::wlcs_stat_t stat;

  wlcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  wlcs_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .func(func), .now_seconds(now_seconds), .tried_mask(tried_mask),
    .peer_index(peer_index), .failed(failed), .cmd(cmd), .stat(stat),
    .res_status(status), .res_peer(chosen_peer), .res_tried(new_tried_mask)
  );

endmodule

/* design/wlcs_datapath.sv */
// Datapath of the peer selector: registers, peer state and per-peer scan logic.
module wlcs_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_en,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   func,
  input  logic [31:0]            now_seconds,
  input  logic [7:0]             tried_mask,
  input  logic [2:0]             peer_index,
  input  logic                   failed,
  input  wlcs_pkg::wlcs_cmd_t    cmd,
  output wlcs_pkg::wlcs_stat_t   stat,
  output logic [1:0]             res_status,
  output logic [2:0]             res_peer,
  output logic [7:0]             res_tried
);

  logic [31:0] peer_weights;
  logic [31:0] peer_fail_limits;
  logic [63:0] peer_fail_windows;
  logic [7:0]  down_mask;
  logic [3:0]  peer_count;

  logic [15:0] conn_counts [wlcs_pkg::NumPeers];
  logic [7:0]  fail_counts [wlcs_pkg::NumPeers];
  logic [31:0] check_times [wlcs_pkg::NumPeers];
  logic signed [9:0] smooth_weights [wlcs_pkg::NumPeers];

  logic        op_func;
  logic [31:0] op_now;
  logic [7:0]  op_tried;
  logic [2:0]  op_pidx;
  logic        op_failed;

  logic [2:0]  idx;
  logic [2:0]  best;
  logic        found;
  logic        many;
  logic signed [7:0] total;

  logic [3:0]  n_act;
  logic [3:0]  w_i, w_b, lim_i;
  logic [7:0]  win_i, win_b;
  logic        elig;
  logic [19:0] lhs, rhs;
  logic signed [10:0] sw_add;
  logic signed [9:0]  sw_sat;
  logic signed [11:0] sw_sub;
  logic [31:0] age_i, age_b;
  logic [2:0]  best_next;

  // The second scan starts at the final minimum, including an update on the last peer.
  function automatic logic [2:0] best_scan_start(input logic e, input logic f,
      input logic [19:0] l, input logic [19:0] r, input logic [2:0] i, input logic [2:0] b);
    logic [2:0] s;
    s = b;
    if (e && (!f || l < r)) s = i;
    return s;
  endfunction

  always_comb begin
    if (peer_count == 4'd0) n_act = 4'd1;
    else if (peer_count > 4'd8) n_act = 4'd8;
    else n_act = peer_count;
    w_i   = wlcs_pkg::weight_of(peer_weights, idx);
    w_b   = wlcs_pkg::weight_of(peer_weights, best);
    lim_i = peer_fail_limits[4*idx +: 4];
    win_i = peer_fail_windows[8*idx +: 8];
    win_b = peer_fail_windows[8*best +: 8];
    age_i = op_now - check_times[idx];
    age_b = op_now - check_times[best];
    elig  = !op_tried[idx] && !down_mask[idx] &&
            !(lim_i != 4'd0 && fail_counts[idx] >= {4'd0, lim_i} && age_i <= {24'd0, win_i});
    lhs   = conn_counts[idx] * w_b;
    rhs   = conn_counts[best] * w_i;
    sw_add = 11'(smooth_weights[idx]) + 11'(signed'({1'b0, w_i}));
    if (sw_add > 11'sd511) sw_sat = 10'sd511;
    else if (sw_add < -11'sd512) sw_sat = -10'sd512;
    else sw_sat = sw_add[9:0];
    sw_sub = 12'(smooth_weights[best]) - 12'(total);
    best_next = best;
    if (sw_sat > smooth_weights[best]) best_next = idx;
  end

  assign stat.is_release = op_func;
  assign stat.scan_last  = ({1'b0, idx} + 4'd1 >= n_act);
  assign stat.found      = found;
  assign stat.many       = many;

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_weights      <= 32'h1111_1111;
      peer_fail_limits  <= 32'h1111_1111;
      peer_fail_windows <= 64'h0A0A_0A0A_0A0A_0A0A;
      down_mask         <= 8'd0;
      peer_count        <= 4'd8;
      for (int k = 0; k < wlcs_pkg::NumPeers; k++) begin
        conn_counts[k]    <= '0;
        fail_counts[k]    <= '0;
        check_times[k]    <= '0;
        smooth_weights[k] <= '0;
      end
      found <= 1'b0;
      many  <= 1'b0;
      idx   <= '0;
      best  <= '0;
      total <= '0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          wlcs_pkg::RegWeights: peer_weights      <= cfg_data[31:0];
          wlcs_pkg::RegLimits:  peer_fail_limits  <= cfg_data[31:0];
          wlcs_pkg::RegWindows: peer_fail_windows <= cfg_data;
          wlcs_pkg::RegDown:    down_mask         <= cfg_data[7:0];
          wlcs_pkg::RegCount:   peer_count        <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        op_func   <= func;
        op_now    <= now_seconds;
        op_tried  <= tried_mask;
        op_pidx   <= peer_index;
        op_failed <= failed;
      end
      if (cmd.scan_clear) begin
        idx   <= '0;
        found <= 1'b0;
        many  <= 1'b0;
        best  <= '0;
        total <= '0;
      end
      if (cmd.scan1) begin
        if (elig) begin
          if (!found) begin
            found <= 1'b1;
            best  <= idx;
            many  <= 1'b0;
          end else if (lhs < rhs) begin
            best <= idx;
            many <= 1'b0;
          end else if (lhs == rhs) begin
            many <= 1'b1;
          end
        end
        if (stat.scan_last) idx <= best_scan_start(elig, found, lhs, rhs, idx, best);
        else idx <= idx + 3'd1;
      end
      if (cmd.scan2) begin
        if (elig && lhs == rhs) begin
          smooth_weights[idx] <= sw_sat;
          total <= total + 8'(signed'({1'b0, w_i}));
          best  <= best_next;
        end
        idx <= idx + 3'd1;
      end
      if (cmd.update) begin
        if (sw_sub > 12'sd511) smooth_weights[best] <= 10'sd511;
        else if (sw_sub < -12'sd512) smooth_weights[best] <= -10'sd512;
        else smooth_weights[best] <= sw_sub[9:0];
        if (age_b > {24'd0, win_b}) check_times[best] <= op_now;
        if (conn_counts[best] != 16'hFFFF) conn_counts[best] <= conn_counts[best] + 16'd1;
        res_status <= wlcs_pkg::StatusChosen;
        res_peer   <= best;
        res_tried  <= op_tried | (8'd1 << best);
      end
      if (cmd.release_op) begin
        if ({1'b0, op_pidx} < n_act) begin
          if (conn_counts[op_pidx] != 16'd0)
            conn_counts[op_pidx] <= conn_counts[op_pidx] - 16'd1;
          if (op_failed) begin
            if (fail_counts[op_pidx] != 8'hFF)
              fail_counts[op_pidx] <= fail_counts[op_pidx] + 8'd1;
            check_times[op_pidx] <= op_now;
          end
        end
        res_status <= wlcs_pkg::StatusRelease;
        res_peer   <= op_pidx;
        res_tried  <= op_tried;
      end
      if (cmd.busy_op) begin
        for (int k = 0; k < wlcs_pkg::NumPeers; k++) fail_counts[k] <= '0;
        res_status <= wlcs_pkg::StatusBusy;
        res_peer   <= '0;
        res_tried  <= op_tried;
      end
    end
  end

endmodule

/* design/wlcs_ctrl.sv */
// Controller state machine that sequences the scans and the update of the peer selector.
module wlcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  wlcs_pkg::wlcs_stat_t stat,
  output wlcs_pkg::wlcs_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DISP  = 6'b000010,
    S_SCAN1 = 6'b000100,
    S_DEC   = 6'b001000,
    S_SCAN2 = 6'b010000,
    S_UPD   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !(state == S_IDLE && slot_free);

  always_comb begin
    state_next = state;
    cmd = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid && slot_free) begin
          cmd.load = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_release) begin
          cmd.release_op = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.scan1 = 1'b1;
        if (stat.scan_last) state_next = S_DEC;
      end
      S_DEC: begin
        if (!stat.found) begin
          cmd.busy_op = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end else if (stat.many) begin
          state_next = S_SCAN2;
        end else begin
          state_next = S_UPD;
        end
      end
      S_SCAN2: begin
        cmd.scan2 = 1'b1;
        if (stat.scan_last) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* design/wlcs_checker.sv */
// Port-level checker for the peer selector, bound to the top level.
module wlcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [7:0] new_tried_mask
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(new_tried_mask))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a transaction while one is in work");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("invalid status code");

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind weighted_least_conn_select wlcs_checker u_wlcs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .new_tried_mask(new_tried_mask)
);

/* test/tb_weighted_least_conn_select.sv */
// Testbench for the weighted least-connections peer selector.
`timescale 1ns / 100ps

module tb_weighted_least_conn_select;

  // Clock and reset. Inputs change on the falling edge and outputs are
  // sampled on the rising edge, so no check depends on event ordering.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [31:0] now_seconds = '0;
  logic [7:0]  tried_mask = '0;
  logic [2:0]  peer_index = '0;
  logic        failed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [2:0]  chosen_peer;
  logic [7:0]  new_tried_mask;

  always #6 clk = ~clk;

  weighted_least_conn_select uut (
    .clk(clk), .rst(rst), .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .now_seconds(now_seconds),
    .tried_mask(tried_mask), .peer_index(peer_index), .failed(failed),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .chosen_peer(chosen_peer), .new_tried_mask(new_tried_mask)
  );

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] peer;
    logic [7:0] mask;
  } pick_t;

  // Shadow copy of the selector's registers and per-peer state.
  logic [31:0] weights_r;
  logic [31:0] limits_r;
  logic [63:0] windows_r;
  logic [7:0]  down_r;
  logic [3:0]  count_r;
  logic [15:0] conns [wlcs_pkg::NumPeers];
  logic [7:0]  fails [wlcs_pkg::NumPeers];
  logic [31:0] checked [wlcs_pkg::NumPeers];
  int          smooth [wlcs_pkg::NumPeers];

  pick_t pending_picks[$];
  int    error_count = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  logic [31:0] clock_secs = 32'd1000;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int peers_in_use();
    int n;
    n = (count_r == 0) ? 1 : int'(count_r);
    if (n > wlcs_pkg::NumPeers) n = wlcs_pkg::NumPeers;
    return n;
  endfunction

  function automatic int peer_weight(input int i);
    int w;
    w = int'(weights_r[4*i +: 4]);
    return (w == 0) ? 1 : w;
  endfunction

  function automatic bit peer_usable(input int i, input logic [31:0] t,
                                     input logic [7:0] tried);
    int lim;
    logic [31:0] age;
    lim = int'(limits_r[4*i +: 4]);
    age = t - checked[i];
    if (tried[i] || down_r[i]) return 1'b0;
    if (lim != 0 && int'(fails[i]) >= lim && age <= {24'd0, windows_r[8*i +: 8]})
      return 1'b0;
    return 1'b1;
  endfunction

  function automatic int clamp_smooth(input int v);
    if (v > 511) return 511;
    if (v < -512) return -512;
    return v;
  endfunction

  // Computes the expected result of one transaction and advances the shadow state.
  function automatic pick_t predict_pick(input logic f, input logic [31:0] t,
                                         input logic [7:0] tried,
                                         input logic [2:0] pidx, input logic fl);
    int n, best, total;
    bit found, many;
    longint lhs, rhs;
    pick_t r;
    n = peers_in_use();
    best = 0; total = 0; found = 0; many = 0;
    if (f) begin
      if (int'(pidx) < n) begin
        if (conns[pidx] != 0) conns[pidx]--;
        if (fl) begin
          if (fails[pidx] != 8'hFF) fails[pidx]++;
          checked[pidx] = t;
        end
      end
      r.status = wlcs_pkg::StatusRelease; r.peer = pidx; r.mask = tried;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      if (!peer_usable(i, t, tried)) continue;
      if (!found) begin
        found = 1; best = i; many = 0;
        continue;
      end
      lhs = longint'(conns[i]) * peer_weight(best);
      rhs = longint'(conns[best]) * peer_weight(i);
      if (lhs < rhs) begin
        best = i; many = 0;
      end else if (lhs == rhs) begin
        many = 1;
      end
    end
    if (!found) begin
      for (int i = 0; i < wlcs_pkg::NumPeers; i++) fails[i] = '0;
      r.status = wlcs_pkg::StatusBusy; r.peer = '0; r.mask = tried;
      return r;
    end
    if (many) begin
      int first;
      first = best;
      for (int i = first; i < n; i++) begin
        if (!peer_usable(i, t, tried)) continue;
        if (longint'(conns[i]) * peer_weight(best) !=
            longint'(conns[best]) * peer_weight(i)) continue;
        smooth[i] = clamp_smooth(smooth[i] + peer_weight(i));
        total += peer_weight(i);
        if (smooth[i] > smooth[best]) best = i;
      end
    end
    smooth[best] = clamp_smooth(smooth[best] - total);
    if (t - checked[best] > {24'd0, windows_r[8*best +: 8]}) checked[best] = t;
    if (conns[best] != 16'hFFFF) conns[best]++;
    r.status = wlcs_pkg::StatusChosen; r.peer = best[2:0];
    r.mask = tried | (8'd1 << best);
    return r;
  endfunction

  // Writes one configuration register; only called while the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_en = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_en = 1'b0;
    case (idx)
      wlcs_pkg::RegWeights: weights_r = val[31:0];
      wlcs_pkg::RegLimits:  limits_r = val[31:0];
      wlcs_pkg::RegWindows: windows_r = val;
      wlcs_pkg::RegDown:    down_r = val[7:0];
      wlcs_pkg::RegCount:   count_r = val[3:0];
      default: ;
    endcase
  endtask

  // Sends one transaction; called at a falling edge, returns at a falling edge.
  task automatic send_request(input logic f, input logic [31:0] t, input logic [7:0] tried,
                              input logic [2:0] pidx, input logic fl);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1; func = f; now_seconds = t; tried_mask = tried;
    peer_index = pidx; failed = fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_picks.push_back(predict_pick(f, t, tried, pidx, fl));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every expected result has come, then lets the block settle.
  task automatic drain_results();
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  // Receiver stall pattern, redrawn each falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        pick_t want;
        want = pending_picks.pop_front();
        if (status != want.status) report_mismatch("status", status, want.status);
        if (chosen_peer != want.peer) report_mismatch("chosen_peer", chosen_peer, want.peer);
        if (new_tried_mask != want.mask)
          report_mismatch("new_tried_mask", new_tried_mask, want.mask);
      end
    end
  end

  // Time advances slowly so fail windows both hold and expire.
  task automatic random_item(input int select_pct);
    logic [7:0] tried;
    tried = ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0;
    clock_secs += $urandom_range(4);
    if ($urandom_range(99) < select_pct)
      send_request(1'b0, clock_secs, tried, 3'($urandom), 1'b0);
    else
      send_request(1'b1, clock_secs, tried, 3'($urandom), $urandom_range(1));
  endtask

  task automatic test_directed();
    send_request(1'b0, 32'd0, 8'h00, 3'd0, 1'b0);
    send_request(1'b0, 32'd0, 8'hFF, 3'd7, 1'b1);
    send_request(1'b0, 32'hFFFFFFFF, 8'h01, 3'd0, 1'b0);
    send_request(1'b1, 32'hFFFFFFFF, 8'hAA, 3'd7, 1'b1);
    send_request(1'b1, 32'd5, 8'h55, 3'd3, 1'b1);
    send_request(1'b1, 32'd6, 8'h00, 3'd4, 1'b0);
    // Release of an idle peer saturates at zero.
    send_request(1'b1, 32'd7, 8'h00, 3'd5, 1'b0);
    send_request(1'b0, 32'd8, 8'h00, 3'd0, 1'b0);
    drain_results();
    write_reg(wlcs_pkg::RegCount, 64'd0);
    send_request(1'b1, 32'd9, 8'h00, 3'd6, 1'b1);
    send_request(1'b0, 32'd9, 8'h00, 3'd0, 1'b0);
    drain_results();
    write_reg(wlcs_pkg::RegCount, 64'd15);
    write_reg(wlcs_pkg::RegWeights, 64'h0000_0000);
    write_reg(wlcs_pkg::RegDown, 64'hFF);
    send_request(1'b0, 32'd10, 8'h00, 3'd0, 1'b0);
    drain_results();
    write_reg(wlcs_pkg::RegDown, 64'h00);
    write_reg(wlcs_pkg::RegWeights, 64'hF1F1_F1F1);
    write_reg(wlcs_pkg::RegLimits, 64'h0000_0000);
    write_reg(wlcs_pkg::RegWindows, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 6; i++) send_request(1'b0, 32'd11, 8'h00, 3'd0, 1'b0);
    drain_results();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      // Hold back once so every result has left before the next request.
      if (i == items / 2) drain_results();
      random_item(70);
    end
    drain_results();
  endtask

  task automatic test_configs();
    write_reg(wlcs_pkg::RegWeights, 64'($urandom));
    write_reg(wlcs_pkg::RegLimits, 64'($urandom) & 64'h3333_3333);
    write_reg(wlcs_pkg::RegWindows,
              {32'($urandom), 32'($urandom)} & 64'h0707_0707_0707_0707);
    write_reg(wlcs_pkg::RegDown, 64'($urandom_range(255)) & 64'h49);
    write_reg(wlcs_pkg::RegCount, 64'($urandom_range(1, 8)));
    test_random_phase(25, 67, 320);
    write_reg(wlcs_pkg::RegWeights, 64'hFFFF_FFFF);
    write_reg(wlcs_pkg::RegLimits, 64'hFFFF_FFFF);
    write_reg(wlcs_pkg::RegWindows, 64'h0);
    write_reg(wlcs_pkg::RegDown, 64'h80);
    write_reg(wlcs_pkg::RegCount, 64'd8);
    test_random_phase(67, 25, 320);
    write_reg(wlcs_pkg::RegWeights, 64'h1234_5678);
    write_reg(wlcs_pkg::RegLimits, 64'h1212_1212);
    write_reg(wlcs_pkg::RegWindows, 64'h0302_0103_0201_0302);
    write_reg(wlcs_pkg::RegDown, 64'h00);
    write_reg(wlcs_pkg::RegCount, 64'd5);
    test_random_phase(0, 0, 340);
  endtask

  initial begin
    weights_r = 32'h1111_1111; limits_r = 32'h1111_1111;
    windows_r = 64'h0A0A_0A0A_0A0A_0A0A; down_r = '0; count_r = 4'd8;
    for (int i = 0; i < wlcs_pkg::NumPeers; i++) begin
      conns[i] = '0; fails[i] = '0; checked[i] = '0; smooth[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_configs();
    if (error_count == 0) begin
      $display("weighted_least_conn_select test passed");
    end else begin
      $display("weighted_least_conn_select test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legitimate run.
  initial begin
    #20ms;
    $display("weighted_least_conn_select test failed");
    $finish;
  end

endmodule
